// File: rtl/pcgbrg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PCG32 bounded generator package
// Constants, request codes and the small helper functions of the generator.
// ---------------------------------------------------------------------------
package pcgbrg_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned DRAW_W  = 32;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W   = 6;

  localparam logic [STATE_W-1:0] PCG_MULT = 64'd6364136223846793005;

  // XSH RR permutation constants
  localparam int unsigned XSH_SHIFT = 18;
  localparam int unsigned XSH_KEEP  = 27;

  typedef enum logic [1:0] {
    FUNC_RAW   = 2'd0,
    FUNC_BELOW = 2'd1,
    FUNC_RANGE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED   = 2'd0,
    CFG_STREAM = 2'd1,
    CFG_RSVD2  = 2'd2,
    CFG_RSVD3  = 2'd3
  } cfg_idx_t;

  // XSH RR output of the state before a step.
  function automatic logic [DRAW_W-1:0] pcg_xsh_rr(input logic [STATE_W-1:0] prev);
    logic [STATE_W-1:0]  mix;
    logic [DRAW_W-1:0]   xs;
    logic [4:0]          rot;
    logic [2*DRAW_W-1:0] dbl;
    mix = ((prev >> XSH_SHIFT) ^ prev) >> XSH_KEEP;
    xs  = mix[DRAW_W-1:0];
    rot = prev[STATE_W-1 -: 5];
    dbl = {xs, xs} >> rot;
    return dbl[DRAW_W-1:0];
  endfunction

  // One step of a restoring remainder: bring in one dividend bit.
  function automatic logic [DRAW_W-1:0] rem_step(input logic [DRAW_W-1:0] rem,
                                                 input logic              dbit,
                                                 input logic [DRAW_W-1:0] divisor);
    logic [DRAW_W:0] t;
    logic [DRAW_W:0] d;
    t = {rem, dbit};
    d = {1'b0, divisor};
    if (t >= d) begin
      t = t - d;
    end
    return t[DRAW_W-1:0];
  endfunction

endpackage

// File: rtl/pcg32_bounded_random_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PCG32 bounded random generator
// PCG XSH RR generator with raw, below-bound and inclusive-range requests.
// ---------------------------------------------------------------------------
// A draw passes the bit-serial 64-bit LCG multiply, a check state, a finish state
// that waits for a free output register, and the output register; each rejected draw
// runs the multiply again. Func 3 and a zero bound give zero straight from the finish state.
// A new request is taken only in idle, after the previous result has left the finish state;
// both remainders run alongside the multiply, one bit per cycle in its first half.
// Reset and each write to the seed or stream register start a reseed with no input transfer.
module pcg32_bounded_random_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pcgbrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcgbrg_pkg::CFG_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [pcgbrg_pkg::DRAW_W-1:0]     in_bound,
  input  logic signed [pcgbrg_pkg::DRAW_W-1:0] in_range_low,
  input  logic signed [pcgbrg_pkg::DRAW_W-1:0] in_range_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcgbrg_pkg::DRAW_W-1:0]     out_draw_value
);
  import pcgbrg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SEED  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t              st_r, st_nxt;
  logic [CFG_W-1:0]    seed_r, seed_nxt;
  logic [CFG_W-1:0]    stream_r, stream_nxt;
  logic [STATE_W-1:0]  lcg_r, lcg_nxt;
  logic [STATE_W-1:0]  acc_r, acc_nxt;
  logic [STATE_W-1:0]  mula_r, mula_nxt;
  logic [STATE_W-1:0]  mulm_r, mulm_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DRAW_W-1:0]   draw_r, draw_nxt;
  logic [DRAW_W-1:0]   b_r, b_nxt;
  logic [DRAW_W-1:0]   off_r, off_nxt;
  logic                raw_r, raw_nxt;
  logic [DRAW_W-1:0]   thr_rem_r, thr_rem_nxt;
  logic [DRAW_W-1:0]   thr_dvd_r, thr_dvd_nxt;
  logic [DRAW_W-1:0]   mod_rem_r, mod_rem_nxt;
  logic [DRAW_W-1:0]   mod_dvd_r, mod_dvd_nxt;
  logic [DRAW_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DRAW_W-1:0]   out_data_r, out_data_nxt;

  logic [STATE_W-1:0]  inc;
  logic [STATE_W-1:0]  acc_sum;
  logic [DRAW_W-1:0]   span;
  logic [DRAW_W-1:0]   lo_u;
  logic [DRAW_W-1:0]   hi_u;
  logic [DRAW_W-1:0]   b_sel;
  logic [DRAW_W-1:0]   perm;
  logic [STATE_W-1:0]  inc_new;
  logic                cfg_hit;
  logic                out_free;

  assign inc     = {stream_r[STATE_W-2:0], 1'b1};
  assign acc_sum = acc_r + (mula_r[0] ? mulm_r : '0);
  assign lo_u    = in_range_low;
  assign hi_u    = in_range_high;
  assign span    = hi_u - lo_u + 32'd1;
  assign b_sel   = (in_func == FUNC_BELOW) ? in_bound : span;
  assign perm    = pcg_xsh_rr(lcg_r);
  assign cfg_hit = cfg_wr_en && ((cfg_index == CFG_SEED) || (cfg_index == CFG_STREAM));
  assign out_free = !out_valid_r || out_ready;

  assign in_ready       = (st_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_draw_value = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    seed_nxt      = seed_r;
    stream_nxt    = stream_r;
    lcg_nxt       = lcg_r;
    acc_nxt       = acc_r;
    mula_nxt      = mula_r;
    mulm_nxt      = mulm_r;
    cnt_nxt       = cnt_r;
    draw_nxt      = draw_r;
    b_nxt         = b_r;
    off_nxt       = off_r;
    raw_nxt       = raw_r;
    thr_rem_nxt   = thr_rem_r;
    thr_dvd_nxt   = thr_dvd_r;
    mod_rem_nxt   = mod_rem_r;
    mod_dvd_nxt   = mod_dvd_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    inc_new       = inc;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          off_nxt     = (in_func == FUNC_RANGE) ? lo_u : '0;
          b_nxt       = b_sel;
          raw_nxt     = (in_func == FUNC_RAW) || ((in_func == FUNC_RANGE) && (span == '0));
          draw_nxt    = perm;
          acc_nxt     = inc;
          mula_nxt    = lcg_r;
          mulm_nxt    = PCG_MULT;
          cnt_nxt     = '0;
          thr_rem_nxt = '0;
          thr_dvd_nxt = '0 - b_sel;
          mod_rem_nxt = '0;
          mod_dvd_nxt = perm;
          st_nxt      = ST_RUN;
          // Unused selector and a zero bound give zero without a step.
          if ((in_func == FUNC_NONE) || ((in_func == FUNC_BELOW) && (in_bound == '0))) begin
            res_nxt = '0;
            st_nxt  = ST_FIN;
          end
        end
      end
      ST_SEED, ST_RUN: begin
        acc_nxt  = acc_sum;
        mula_nxt = mula_r >> 1;
        mulm_nxt = mulm_r << 1;
        cnt_nxt  = cnt_r + 6'd1;
        if (!cnt_r[CNT_W-1]) begin
          thr_rem_nxt = rem_step(thr_rem_r, thr_dvd_r[DRAW_W-1], b_r);
          thr_dvd_nxt = thr_dvd_r << 1;
          mod_rem_nxt = rem_step(mod_rem_r, mod_dvd_r[DRAW_W-1], b_r);
          mod_dvd_nxt = mod_dvd_r << 1;
        end
        if (cnt_r == '1) begin
          lcg_nxt = acc_sum;
          st_nxt  = (st_r == ST_SEED) ? ST_IDLE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (raw_r) begin
          res_nxt = off_r + draw_r;
          st_nxt  = ST_FIN;
        end else if (draw_r >= thr_rem_r) begin
          res_nxt = off_r + mod_rem_r;
          st_nxt  = ST_FIN;
        end else begin
          // Draw fell below the threshold: take another one.
          draw_nxt    = perm;
          acc_nxt     = inc;
          mula_nxt    = lcg_r;
          mulm_nxt    = PCG_MULT;
          cnt_nxt     = '0;
          thr_rem_nxt = '0;
          thr_dvd_nxt = '0 - b_r;
          mod_rem_nxt = '0;
          mod_dvd_nxt = perm;
          st_nxt      = ST_RUN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // A seed or stream register write reseeds: state becomes inc + seed, then one step.
    if (cfg_hit) begin
      if (cfg_index == CFG_SEED) begin
        seed_nxt = cfg_data;
      end else begin
        stream_nxt = cfg_data;
      end
      inc_new  = {stream_nxt[STATE_W-2:0], 1'b1};
      acc_nxt  = inc_new;
      mula_nxt = seed_nxt + inc_new;
      mulm_nxt = PCG_MULT;
      cnt_nxt  = '0;
      st_nxt   = ST_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SEED;
      seed_r      <= '0;
      stream_r    <= '0;
      acc_r       <= 64'd1;
      mula_r      <= 64'd1;
      mulm_r      <= PCG_MULT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      seed_r      <= seed_nxt;
      stream_r    <= stream_nxt;
      acc_r       <= acc_nxt;
      mula_r      <= mula_nxt;
      mulm_r      <= mulm_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_r      <= lcg_nxt;
    draw_r     <= draw_nxt;
    b_r        <= b_nxt;
    off_r      <= off_nxt;
    raw_r      <= raw_nxt;
    thr_rem_r  <= thr_rem_nxt;
    thr_dvd_r  <= thr_dvd_nxt;
    mod_rem_r  <= mod_rem_nxt;
    mod_dvd_r  <= mod_dvd_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_cfg_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (st_r == ST_SEED) && !in_ready)
    else $error("register write did not start a reseed");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FIN) && out_free) |=> out_valid && (st_r == ST_IDLE || st_r == ST_SEED))
    else $error("finished result not moved to the output register");

endmodule
